FILE: src/keyed_priority_queue_macros.svh
// assertion macros used by the keyed priority queue
`ifndef KEYED_PRIORITY_QUEUE_MACROS_SVH
`define KEYED_PRIORITY_QUEUE_MACROS_SVH

`ifndef NO_ASSERTIONS

// check that is switched off while reset is high
`define KPQ_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// check that also runs during reset
`define KPQ_ASSERT_ALWAYS(lbl, clk, prop, msg) \
   lbl: assert property (@(posedge clk) prop) else $error(msg);

`else

`define KPQ_ASSERT(lbl, clk, rst, prop, msg)
`define KPQ_ASSERT_ALWAYS(lbl, clk, prop, msg)

`endif

`endif

FILE: src/kpq_pkg.sv
// types and codes of the keyed priority queue
package kpq_pkg;

   // operation codes on the request side
   typedef enum logic [1:0] {
      OP_INSERT = 2'd0,
      OP_POP    = 2'd1,
      OP_REMOVE = 2'd2,
      OP_LIST   = 2'd3
   } kpq_op_type;

   // status codes on the response side
   typedef enum logic [2:0] {
      ST_ADDED    = 3'd0,
      ST_DUP      = 3'd1,
      ST_POPPED   = 3'd2,
      ST_NOTFOUND = 3'd3,
      ST_REMOVED  = 3'd4,
      ST_EMPTY    = 3'd5,
      ST_LISTED   = 3'd6,
      ST_FULL     = 3'd7
   } kpq_status_type;

   // command broadcast to every cell
   typedef enum logic [2:0] {
      CELL_HOLD   = 3'd0,
      CELL_INSERT = 3'd1,
      CELL_POP    = 3'd2,
      CELL_REMOVE = 3'd3,
      CELL_ROTATE = 3'd4
   } kpq_cmd_type;

   typedef struct packed {
      kpq_cmd_type cmd;
   } kpq_ctrl_type;

   // flags handed from one cell to the next one down the chain
   typedef struct packed {
      logic valid;   // cell holds an entry
      logic stay;    // cell keeps its entry on insert
      logic hit;     // key matched at this cell or above
   } kpq_link_type;

   // controller states
   typedef enum logic [1:0] {
      S_IDLE = 2'd0,
      S_EXEC = 2'd1,
      S_LIST = 2'd2
   } kpq_state_type;

endpackage

FILE: src/kpq_cell.sv
// one storage cell of the sorted queue chain
module kpq_cell
   import kpq_pkg::*;
#(
   parameter int ID_BITS   = 16,
   parameter int PRIO_BITS = 8
) (
   input  logic                 clock,
   input  logic                 reset,
   input  kpq_ctrl_type         ctrl,
   input  logic [ID_BITS-1:0]   key,
   input  logic [PRIO_BITS-1:0] new_prio,
   input  logic [ID_BITS-1:0]   head_id,
   input  logic [PRIO_BITS-1:0] head_prio,
   input  kpq_link_type         prev_link,
   input  logic [ID_BITS-1:0]   prev_id,
   input  logic [PRIO_BITS-1:0] prev_prio,
   input  logic                 nxt_valid,
   input  logic [ID_BITS-1:0]   nxt_id,
   input  logic [PRIO_BITS-1:0] nxt_prio,
   output kpq_link_type         link,
   output logic [ID_BITS-1:0]   cell_id,
   output logic [PRIO_BITS-1:0] cell_prio
);

   logic                 valid_ff, valid_in;
   logic [ID_BITS-1:0]   id_ff, id_in;
   logic [PRIO_BITS-1:0] prio_ff, prio_in;
   logic                 stay, match;

   // local compares against the broadcast request
   assign stay  = valid_ff && !(prio_ff < new_prio);
   assign match = valid_ff && (id_ff == key);

   assign link.valid = valid_ff;
   assign link.stay  = stay;
   assign link.hit   = prev_link.hit | match;
   assign cell_id    = id_ff;
   assign cell_prio  = prio_ff;

   // next entry of this cell
   always_comb begin
      valid_in = valid_ff;
      id_in    = id_ff;
      prio_in  = prio_ff;
      case (ctrl.cmd)
         CELL_INSERT: begin
            if (!stay) begin
               if (prev_link.stay) begin
                  valid_in = 1'b1;
                  id_in    = key;
                  prio_in  = new_prio;
               end else begin
                  valid_in = prev_link.valid;
                  id_in    = prev_id;
                  prio_in  = prev_prio;
               end
            end
         end
         CELL_POP: begin
            valid_in = nxt_valid;
            id_in    = nxt_id;
            prio_in  = nxt_prio;
         end
         CELL_REMOVE: begin
            if (link.hit) begin
               valid_in = nxt_valid;
               id_in    = nxt_id;
               prio_in  = nxt_prio;
            end
         end
         CELL_ROTATE: begin
            if (nxt_valid) begin
               id_in   = nxt_id;
               prio_in = nxt_prio;
            end else if (valid_ff) begin
               id_in   = head_id;
               prio_in = head_prio;
            end
         end
         default: begin
         end
      endcase
   end

   // occupancy flag
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   // entry payload
   always_ff @(posedge clock) begin
      id_ff   <= id_in;
      prio_ff <= prio_in;
   end

endmodule

FILE: src/keyed_priority_queue.sv
// keyed priority queue: chain of sorted cells with a controller and response register
// a request is accepted in idle and executed in exec, which loads the response register
// lists of two or more entries go on in S_LIST; every other request returns to idle from exec
// no request is taken outside idle; a response held by a low rsp_tready stalls the controller
// the chain updates with the response register load; list rotates it once per emitted entry
// reset (synchronous, active high) empties the queue and drops any pending response
`include "keyed_priority_queue_macros.svh"

module keyed_priority_queue
   import kpq_pkg::*;
#(
   parameter int DEPTH     = 16,
   parameter int ID_BITS   = 16,
   parameter int PRIO_BITS = 8,
   localparam int DATA_W   = ((ID_BITS + PRIO_BITS + 7) / 8) * 8
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_tvalid,
   output logic              req_tready,
   input  logic [DATA_W-1:0] req_tdata,    // id, priority_req
   input  logic [1:0]        req_tuser,    // op
   output logic              rsp_tvalid,
   input  logic              rsp_tready,
   output logic [DATA_W-1:0] rsp_tdata,    // id_out, priority_out
   output logic [2:0]        rsp_tuser,    // status
   output logic              rsp_tlast
);

   localparam int CNT_W = $clog2(DEPTH + 1);

   // request and response registers
   kpq_op_type           op_ff, op_in;
   logic [ID_BITS-1:0]   key_ff, key_in;
   logic [PRIO_BITS-1:0] pri_ff, pri_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   kpq_status_type       rsp_status_ff, rsp_status_in;
   logic [ID_BITS-1:0]   rsp_id_ff, rsp_id_in;
   logic [PRIO_BITS-1:0] rsp_prio_ff, rsp_prio_in;
   logic                 rsp_last_ff, rsp_last_in;

   kpq_state_type        state_ff, state_in;
   logic [CNT_W-1:0]     count_ff, count_in;
   logic [CNT_W-1:0]     idx_ff, idx_in;

   kpq_ctrl_type         ctrl;
   logic                 out_free, found, full, list_end;

   // cell chain wiring
   kpq_link_type         link_w [DEPTH];
   kpq_link_type         prev_link_w [DEPTH];
   logic [ID_BITS-1:0]   cell_id_w [DEPTH];
   logic [PRIO_BITS-1:0] cell_prio_w [DEPTH];
   logic [ID_BITS-1:0]   prev_id_w [DEPTH];
   logic [PRIO_BITS-1:0] prev_prio_w [DEPTH];
   logic                 nxt_valid_w [DEPTH];
   logic [ID_BITS-1:0]   nxt_id_w [DEPTH];
   logic [PRIO_BITS-1:0] nxt_prio_w [DEPTH];
   logic [DEPTH-1:0]     valid_vec;

   for (genvar i = 0; i < DEPTH; i++) begin : g_cell
      if (i == 0) begin : g_top
         assign prev_link_w[i] = '{valid: 1'b1, stay: 1'b1, hit: 1'b0};
         assign prev_id_w[i]   = '0;
         assign prev_prio_w[i] = '0;
      end else begin : g_mid
         assign prev_link_w[i] = link_w[i-1];
         assign prev_id_w[i]   = cell_id_w[i-1];
         assign prev_prio_w[i] = cell_prio_w[i-1];
      end
      if (i == DEPTH - 1) begin : g_tail
         assign nxt_valid_w[i] = 1'b0;
         assign nxt_id_w[i]    = '0;
         assign nxt_prio_w[i]  = '0;
      end else begin : g_body
         assign nxt_valid_w[i] = link_w[i+1].valid;
         assign nxt_id_w[i]    = cell_id_w[i+1];
         assign nxt_prio_w[i]  = cell_prio_w[i+1];
      end
      assign valid_vec[i] = link_w[i].valid;

      kpq_cell #(
         .ID_BITS   (ID_BITS),
         .PRIO_BITS (PRIO_BITS)
      ) u_cell (
         .clock     (clock),
         .reset     (reset),
         .ctrl      (ctrl),
         .key       (key_ff),
         .new_prio  (pri_ff),
         .head_id   (cell_id_w[0]),
         .head_prio (cell_prio_w[0]),
         .prev_link (prev_link_w[i]),
         .prev_id   (prev_id_w[i]),
         .prev_prio (prev_prio_w[i]),
         .nxt_valid (nxt_valid_w[i]),
         .nxt_id    (nxt_id_w[i]),
         .nxt_prio  (nxt_prio_w[i]),
         .link      (link_w[i]),
         .cell_id   (cell_id_w[i]),
         .cell_prio (cell_prio_w[i])
      );
   end

   assign found    = link_w[DEPTH-1].hit;
   assign full     = (count_ff == CNT_W'(DEPTH));
   assign out_free = !rsp_valid_ff || rsp_tready;
   assign list_end = (CNT_W'(idx_ff + 1'b1) == count_ff);

   // controller: next state, cell command and response load
   always_comb begin
      state_in      = state_ff;
      count_in      = count_ff;
      idx_in        = idx_ff;
      op_in         = op_ff;
      key_in        = key_ff;
      pri_in        = pri_ff;
      ctrl.cmd      = CELL_HOLD;
      req_tready    = 1'b0;
      rsp_valid_in  = rsp_valid_ff && !rsp_tready;
      rsp_status_in = rsp_status_ff;
      rsp_id_in     = rsp_id_ff;
      rsp_prio_in   = rsp_prio_ff;
      rsp_last_in   = rsp_last_ff;
      case (state_ff)
         S_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               op_in    = kpq_op_type'(req_tuser);
               key_in   = req_tdata[ID_BITS-1:0];
               pri_in   = req_tdata[ID_BITS +: PRIO_BITS];
               state_in = S_EXEC;
            end
         end
         S_EXEC: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_last_in  = 1'b1;
               rsp_id_in    = key_ff;
               rsp_prio_in  = '0;
               state_in     = S_IDLE;
               case (op_ff)
                  OP_INSERT: begin
                     if (found) begin
                        rsp_status_in = ST_DUP;
                     end else if (full) begin
                        rsp_status_in = ST_FULL;
                     end else begin
                        rsp_status_in = ST_ADDED;
                        ctrl.cmd      = CELL_INSERT;
                        count_in      = CNT_W'(count_ff + 1'b1);
                     end
                  end
                  OP_POP: begin
                     if (count_ff == '0) begin
                        rsp_status_in = ST_EMPTY;
                        rsp_id_in     = '0;
                     end else begin
                        rsp_status_in = ST_POPPED;
                        rsp_id_in     = cell_id_w[0];
                        rsp_prio_in   = cell_prio_w[0];
                        ctrl.cmd      = CELL_POP;
                        count_in      = CNT_W'(count_ff - 1'b1);
                     end
                  end
                  OP_REMOVE: begin
                     if (found) begin
                        rsp_status_in = ST_REMOVED;
                        ctrl.cmd      = CELL_REMOVE;
                        count_in      = CNT_W'(count_ff - 1'b1);
                     end else begin
                        rsp_status_in = ST_NOTFOUND;
                     end
                  end
                  default: begin
                     if (count_ff == '0) begin
                        rsp_status_in = ST_EMPTY;
                        rsp_id_in     = '0;
                     end else begin
                        rsp_status_in = ST_LISTED;
                        rsp_id_in     = cell_id_w[0];
                        rsp_prio_in   = cell_prio_w[0];
                        rsp_last_in   = (count_ff == CNT_W'(1));
                        ctrl.cmd      = CELL_ROTATE;
                        idx_in        = CNT_W'(1);
                        if (count_ff != CNT_W'(1)) begin
                           state_in = S_LIST;
                        end
                     end
                  end
               endcase
            end
         end
         S_LIST: begin
            if (out_free) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = ST_LISTED;
               rsp_id_in     = cell_id_w[0];
               rsp_prio_in   = cell_prio_w[0];
               rsp_last_in   = list_end;
               ctrl.cmd      = CELL_ROTATE;
               idx_in        = CNT_W'(idx_ff + 1'b1);
               if (list_end) begin
                  state_in = S_IDLE;
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         idx_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         idx_ff       <= idx_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // request and response payload
   always_ff @(posedge clock) begin
      op_ff         <= op_in;
      key_ff        <= key_in;
      pri_ff        <= pri_in;
      rsp_status_ff <= rsp_status_in;
      rsp_id_ff     <= rsp_id_in;
      rsp_prio_ff   <= rsp_prio_in;
      rsp_last_ff   <= rsp_last_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_status_ff;
   assign rsp_tdata  = DATA_W'({rsp_prio_ff, rsp_id_ff});
   assign rsp_tlast  = rsp_last_ff;

   // occupied cells always form a prefix of the chain matching the count
   logic [DEPTH:0] thermo_w;
   logic           cells_ok, head_ok, single_rsp, in_list;
   assign thermo_w   = ((DEPTH + 1)'(1) << count_ff) - (DEPTH + 1)'(1);
   assign cells_ok   = (valid_vec == thermo_w[DEPTH-1:0]);
   // head not below its neighbor while the chain is in sorted order
   assign head_ok    = !valid_vec[1] || (cell_prio_w[0] >= cell_prio_w[1]);
   assign single_rsp = rsp_tvalid && (rsp_tuser != ST_LISTED);
   assign in_list    = (state_ff == S_LIST);

   `KPQ_ASSERT(a_cells_match_count, clock, reset, cells_ok, "cell valids disagree with count")
   `KPQ_ASSERT(a_count_bound, clock, reset, count_ff <= CNT_W'(DEPTH), "count exceeds depth")
   `KPQ_ASSERT(a_single_last, clock, reset, single_rsp |-> rsp_tlast, "single response lacks last")
   `KPQ_ASSERT(a_list_index, clock, reset, in_list |-> idx_ff < count_ff, "list index past count")
   `KPQ_ASSERT(a_head_order, clock, reset, !in_list |-> head_ok, "head out of order")
   `KPQ_ASSERT_ALWAYS(a_reset_clears, clock, reset |=> !rsp_tvalid, "valid after reset")

endmodule
